[hdl/u8cp_pkg.sv]
package u8cp_pkg;

  // Field widths of the two channels.
  localparam int BYTE_W = 8;
  localparam int CP_W   = 21;

  // Code point values.
  localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [CP_W-1:0] MAX_SCALAR     = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO        = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI        = 21'h00DFFF;

  // Lead byte ranges and second byte limits.
  localparam logic [BYTE_W-1:0] LEAD2_LO  = 8'hC2;
  localparam logic [BYTE_W-1:0] LEAD2_HI  = 8'hDF;
  localparam logic [BYTE_W-1:0] LEAD3_LO  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD3_HI  = 8'hEF;
  localparam logic [BYTE_W-1:0] LEAD4_LO  = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD4_HI  = 8'hF4;
  localparam logic [BYTE_W-1:0] LEAD_E0   = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_ED   = 8'hED;
  localparam logic [BYTE_W-1:0] LEAD_F0   = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD_F4   = 8'hF4;
  localparam logic [BYTE_W-1:0] SEC_A0    = 8'hA0;
  localparam logic [BYTE_W-1:0] SEC_90    = 8'h90;
  localparam logic [BYTE_W-1:0] SEC_8F    = 8'h8F;
  localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;

endpackage

[hdl/u8cp_byte_if.sv]
interface u8cp_byte_if;
  logic                         valid;
  logic                         ready;
  logic [u8cp_pkg::BYTE_W-1:0]  in_byte;
  logic                         stream_end;

  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink (input valid, input in_byte, input stream_end, output ready);
endinterface

[hdl/u8cp_cp_if.sv]
interface u8cp_cp_if;
  logic                       valid;
  logic                       ready;
  logic [u8cp_pkg::CP_W-1:0]  code_point;
  logic                       run_last;
  logic                       text_last;

  modport source (output valid, output code_point, output run_last, output text_last,
                  input ready);
  modport sink (input valid, input code_point, input run_last, input text_last,
                output ready);
endinterface

[hdl/utf8_to_codepoint_decoder.sv]
// A byte passes the input register and is then decoded into a two-entry result queue,
// from whose head its code points are sent.
// Throughput: one byte per cycle; a byte that causes k results gives k output beats,
// and bytes stall only while the two-entry result queue is full.
// Reset (rst, synchronous, active high) empties the input register and the queue
// and leaves nothing held; the held continuation bytes are not cleared.
module utf8_to_codepoint_decoder (
  input  logic        clk,
  input  logic        rst,
  u8cp_byte_if.sink   bytes,
  u8cp_cp_if.source   points
);

  // One queued step: up to four results, all U+FFFD except the one at sp_pos.
  typedef struct packed {
    logic [1:0]                 last_idx;
    logic [1:0]                 sp_pos;
    logic [u8cp_pkg::CP_W-1:0]  sp_cp;
    logic                       text_end;
  } step_rec_t;

  function automatic logic [1:0] cont_needed(input logic [u8cp_pkg::BYTE_W-1:0] lead);
    logic [1:0] n;
    n = 2'd0;
    if (lead inside {[u8cp_pkg::LEAD2_LO:u8cp_pkg::LEAD2_HI]}) n = 2'd1;
    if (lead inside {[u8cp_pkg::LEAD3_LO:u8cp_pkg::LEAD3_HI]}) n = 2'd2;
    if (lead inside {[u8cp_pkg::LEAD4_LO:u8cp_pkg::LEAD4_HI]}) n = 2'd3;
    return n;
  endfunction

  // Input register.
  logic                           s1_valid;
  logic [u8cp_pkg::BYTE_W-1:0]    s1_byte;
  logic                           s1_end;
  logic                           s1_fire;

  // Decoder state.
  logic                           pending;
  logic [u8cp_pkg::BYTE_W-1:0]    held_lead;
  logic [1:0]                     held_count;
  logic [u8cp_pkg::BYTE_W-1:0]    held_cont [2];

  // Result queue.
  step_rec_t                      q [2];
  logic                           q_head;
  logic                           q_tail;
  logic [1:0]                     q_cnt;
  logic [1:0]                     beat;
  logic                           push;
  logic                           pop;
  logic                           q_space;
  step_rec_t                      head_rec;

  // Decode outputs.
  logic                           pending_next;
  logic [u8cp_pkg::BYTE_W-1:0]    held_lead_next;
  logic [1:0]                     held_count_next;
  logic                           cont_we;
  logic [2:0]                     n_res;
  step_rec_t                      rec_next;

  assign head_rec = q[q_head];
  assign pop      = points.valid && points.ready && (beat == head_rec.last_idx);
  assign q_space  = (q_cnt != 2'd2) || pop;
  assign s1_fire  = s1_valid && q_space;
  assign push     = s1_fire && (n_res != 3'd0);

  assign bytes.ready = !s1_valid || s1_fire;

  // Decode one byte against the held sequence.
  always_comb begin
    logic [1:0]                 need;
    logic                       bad;
    logic                       take;
    logic [2:0]                 f;
    logic                       t;
    logic [2:0]                 m;
    logic [u8cp_pkg::CP_W-1:0]  cp;
    logic [u8cp_pkg::BYTE_W-1:0] b;
    need = cont_needed(held_lead);
    b    = s1_byte;
    bad  = ((b & u8cp_pkg::CONT_MASK) != u8cp_pkg::CONT_TAG) || (need == 2'd0) ||
           (held_count >= need);
    if (held_count == 2'd0) begin
      if ((held_lead == u8cp_pkg::LEAD_E0 && b < u8cp_pkg::SEC_A0) ||
          (held_lead == u8cp_pkg::LEAD_ED && b >= u8cp_pkg::SEC_A0) ||
          (held_lead == u8cp_pkg::LEAD_F0 && b < u8cp_pkg::SEC_90) ||
          (held_lead == u8cp_pkg::LEAD_F4 && b > u8cp_pkg::SEC_8F)) begin
        bad = 1'b1;
      end
    end
    take = !pending || bad;
    f    = (pending && bad) ? ({1'b0, held_count} + 3'd1) : 3'd0;

    t               = 1'b0;
    rec_next.sp_cp  = u8cp_pkg::REPLACEMENT_CP;
    pending_next    = pending;
    held_lead_next  = held_lead;
    held_count_next = held_count;
    cont_we         = 1'b0;

    case (need)
      2'd1:    cp = {10'd0, held_lead[4:0], b[5:0]};
      2'd2:    cp = {5'd0, held_lead[3:0], held_cont[0][5:0], b[5:0]};
      default: cp = {held_lead[2:0], held_cont[0][5:0], held_cont[1][5:0], b[5:0]};
    endcase

    if (take) begin
      // Decode the byte as a fresh lead.
      pending_next    = 1'b0;
      held_lead_next  = '0;
      held_count_next = 2'd0;
      if (!b[7]) begin
        t              = 1'b1;
        rec_next.sp_cp = {{(u8cp_pkg::CP_W-u8cp_pkg::BYTE_W){1'b0}}, b};
      end else if (cont_needed(b) != 2'd0) begin
        pending_next   = 1'b1;
        held_lead_next = b;
      end else begin
        t = 1'b1;
      end
    end else if (({1'b0, held_count} + 3'd1) == {1'b0, need}) begin
      // Sequence complete.
      t = 1'b1;
      if (cp > u8cp_pkg::MAX_SCALAR ||
          cp inside {[u8cp_pkg::SURR_LO:u8cp_pkg::SURR_HI]}) begin
        rec_next.sp_cp = u8cp_pkg::REPLACEMENT_CP;
      end else begin
        rec_next.sp_cp = cp;
      end
      pending_next    = 1'b0;
      held_lead_next  = '0;
      held_count_next = 2'd0;
    end else begin
      cont_we         = 1'b1;
      held_count_next = held_count + 2'd1;
    end

    // End of text flushes whatever is still held.
    m = 3'd0;
    if (s1_end) begin
      if (pending_next) m = {1'b0, held_count_next} + 3'd1;
      pending_next    = 1'b0;
      held_lead_next  = '0;
      held_count_next = 2'd0;
    end

    n_res             = f + {2'b00, t} + m;
    rec_next.sp_pos   = f[1:0];
    rec_next.last_idx = n_res[1:0] - 2'd1;
    rec_next.text_end = s1_end;
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (bytes.ready) begin
      s1_valid <= bytes.valid;
    end
    if (bytes.valid && bytes.ready) begin
      s1_byte <= bytes.in_byte;
      s1_end  <= bytes.stream_end;
    end
  end

  // Decoder state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= 1'b0;
      held_lead  <= '0;
      held_count <= 2'd0;
    end else if (s1_fire) begin
      pending    <= pending_next;
      held_lead  <= held_lead_next;
      held_count <= held_count_next;
    end
    if (s1_fire && cont_we) begin
      held_cont[held_count[0]] <= s1_byte;
    end
  end

  // Result queue and output beat counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_head <= 1'b0;
      q_tail <= 1'b0;
      q_cnt  <= 2'd0;
      beat   <= 2'd0;
    end else begin
      if (push) q_tail <= ~q_tail;
      if (pop) q_head <= ~q_head;
      q_cnt <= q_cnt + {1'b0, push} - {1'b0, pop};
      if (pop) begin
        beat <= 2'd0;
      end else if (points.valid && points.ready) begin
        beat <= beat + 2'd1;
      end
    end
    if (push) begin
      q[q_tail] <= rec_next;
    end
  end

  assign points.valid      = (q_cnt != 2'd0);
  assign points.code_point = (beat == head_rec.sp_pos) ? head_rec.sp_cp
                                                       : u8cp_pkg::REPLACEMENT_CP;
  assign points.run_last   = (beat == head_rec.last_idx);
  assign points.text_last  = (beat == head_rec.last_idx) && head_rec.text_end;

`ifndef NO_ASSERTIONS
  a_q_bound: assert property (@(posedge clk) disable iff (rst) q_cnt != 2'd3)
    else $error("result queue count out of range");
  a_text_run: assert property (@(posedge clk) disable iff (rst)
    points.valid && points.text_last |-> points.run_last)
    else $error("text_last without run_last");
  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    !pending |-> held_count == 2'd0)
    else $error("continuation bytes held without a lead");
  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    bytes.valid && bytes.ready |=> s1_valid)
    else $error("accepted beat lost at input register");
`endif

endmodule

[tb/tb_utf8_to_codepoint_decoder.sv]
`timescale 1ns / 100ps

module tb_utf8_to_codepoint_decoder;

  typedef logic [u8cp_pkg::BYTE_W-1:0] byte_t;
  typedef logic [u8cp_pkg::CP_W-1:0]   cp_t;

  // One expected beat on the code point channel.
  typedef struct packed {
    cp_t  code_point;
    logic run_last;
    logic text_last;
  } point_t;

  // Shapes of random byte runs.
  typedef enum {
    SEQ_ASCII,
    SEQ_TWO,
    SEQ_THREE,
    SEQ_FOUR,
    SEQ_NOISE,
    SEQ_TRUNCATED,
    SEQ_BAD_SECOND
  } seq_kind_t;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 120;
  localparam int SETTLE_CYCLES = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;

  u8cp_byte_if byte_ch ();
  u8cp_cp_if  point_ch ();

  utf8_to_codepoint_decoder dut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (byte_ch),
    .points (point_ch)
  );

  // Decoder state mirrored by the predictor.
  byte_t seq_lead;
  int    seq_cont_count;
  byte_t seq_cont [2];
  logic  seq_open;

  cp_t    decoded_cps [$];
  point_t pending_points [$];

  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int stall_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s", $time, msg);
    end
  endfunction

  function automatic int cont_needed(byte_t lead);
    if (lead >= u8cp_pkg::LEAD2_LO && lead <= u8cp_pkg::LEAD2_HI) return 1;
    if (lead >= u8cp_pkg::LEAD3_LO && lead <= u8cp_pkg::LEAD3_HI) return 2;
    if (lead >= u8cp_pkg::LEAD4_LO && lead <= u8cp_pkg::LEAD4_HI) return 3;
    return 0;
  endfunction

  function automatic logic second_out_of_range(byte_t lead, byte_t b);
    return (lead == u8cp_pkg::LEAD_E0 && b < u8cp_pkg::SEC_A0) ||
           (lead == u8cp_pkg::LEAD_ED && b >= u8cp_pkg::SEC_A0) ||
           (lead == u8cp_pkg::LEAD_F0 && b < u8cp_pkg::SEC_90) ||
           (lead == u8cp_pkg::LEAD_F4 && b > u8cp_pkg::SEC_8F);
  endfunction

  // Append one decoded code point to the list for the current byte.
  function automatic void add_cp(cp_t cp);
    decoded_cps.insert(decoded_cps.size(), cp);
  endfunction

  // Replace the held lead and each held continuation byte by U+FFFD.
  function automatic void flush_held();
    int k;
    if (!seq_open) return;
    add_cp(u8cp_pkg::REPLACEMENT_CP);
    for (k = 0; k < seq_cont_count; k++) begin
      add_cp(u8cp_pkg::REPLACEMENT_CP);
    end
    seq_open = 1'b0;
    seq_cont_count = 0;
    seq_lead = '0;
  endfunction

  // Treat a byte as the start of a new character.
  function automatic void start_sequence(byte_t b);
    if (!b[7]) begin
      add_cp(cp_t'(b));
    end else if (cont_needed(b) != 0) begin
      seq_open = 1'b1;
      seq_lead = b;
      seq_cont_count = 0;
    end else begin
      add_cp(u8cp_pkg::REPLACEMENT_CP);
    end
  endfunction

  // Work out the code point beats that one accepted byte causes.
  function automatic void decode_byte(byte_t b, logic last_of_text);
    int     need;
    int     idx;
    int     i;
    logic   bad;
    cp_t    cp;
    point_t pt;
    decoded_cps.delete();
    if (!seq_open) begin
      start_sequence(b);
    end else begin
      need = cont_needed(seq_lead);
      idx = seq_cont_count;
      bad = (b & u8cp_pkg::CONT_MASK) != u8cp_pkg::CONT_TAG;
      if (!bad && idx == 0 && second_out_of_range(seq_lead, b)) bad = 1'b1;
      if (need == 0 || idx >= need) bad = 1'b1;
      if (bad) begin
        flush_held();
        start_sequence(b);
      end else if (idx + 1 == need) begin
        case (need)
          1: cp = {10'd0, seq_lead[4:0], b[5:0]};
          2: cp = {5'd0, seq_lead[3:0], seq_cont[0][5:0], b[5:0]};
          default: cp = {seq_lead[2:0], seq_cont[0][5:0], seq_cont[1][5:0], b[5:0]};
        endcase
        if (cp > u8cp_pkg::MAX_SCALAR ||
            (cp >= u8cp_pkg::SURR_LO && cp <= u8cp_pkg::SURR_HI)) begin
          cp = u8cp_pkg::REPLACEMENT_CP;
        end
        add_cp(cp);
        seq_open = 1'b0;
        seq_cont_count = 0;
        seq_lead = '0;
      end else begin
        seq_cont[idx] = b;
        seq_cont_count = idx + 1;
      end
    end
    if (last_of_text) flush_held();
    for (i = 0; i < decoded_cps.size(); i++) begin
      pt.code_point = decoded_cps[i];
      pt.run_last = (i == decoded_cps.size() - 1);
      pt.text_last = last_of_text && (i == decoded_cps.size() - 1);
      pending_points.insert(pending_points.size(), pt);
    end
  endfunction

  // Offer one byte, idling first at random, and predict once it is taken.
  task automatic send_byte(input byte_t b, input logic last_of_text);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.in_byte <= b;
    byte_ch.stream_end <= last_of_text;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    decode_byte(b, last_of_text);
  endtask

  task automatic send_text(input byte_t text [$], input logic end_on_last);
    foreach (text[i]) begin
      send_byte(text[i], end_on_last && (i == text.size() - 1));
    end
  endtask

  task automatic wait_drained();
    while (pending_points.size() != 0) @(posedge clk);
  endtask

  task automatic test_ascii();
    send_text('{8'h00, 8'h7F}, 1'b1);
  endtask

  task automatic test_two_byte();
    send_text('{8'hC2, 8'h80, 8'hDF, 8'hBF}, 1'b0);
  endtask

  task automatic test_three_byte();
    send_text('{8'hE0, 8'hA0, 8'h80}, 1'b0);
  endtask

  task automatic test_four_byte();
    send_text('{8'hF4, 8'h8F, 8'hBF, 8'hBF}, 1'b0);
  endtask

  // A second byte outside the lead's range turns the lead into U+FFFD and is reread as a lead.
  task automatic test_second_byte_range();
    send_text('{8'hF0, 8'h8F, 8'hF4, 8'h90}, 1'b0);
  endtask

  task automatic test_invalid_leads();
    send_text('{8'hC0, 8'hFF}, 1'b0);
  endtask

  // Broken sequences, and an end of text that flushes a fresh lead too.
  task automatic test_interrupted_sequence();
    send_text('{8'hE2, 8'h82, 8'h41}, 1'b0);
    send_text('{8'hF1, 8'h80, 8'h80, 8'hC3}, 1'b1);
  endtask

  // Mostly well-formed characters with random content, plus noise and broken runs.
  task automatic send_random_text(input int n_bytes);
    seq_kind_t kind;
    int        pick;
    int        len;
    int        sent;
    cp_t       cp;
    cp_t       lo;
    cp_t       hi;
    byte_t     seq [$];
    logic      last_of_text;
    sent = 0;
    while (sent < n_bytes) begin
      seq.delete();
      pick = $urandom_range(0, 99);
      kind = pick < 15 ? SEQ_ASCII : pick < 33 ? SEQ_TWO : pick < 53 ? SEQ_THREE :
             pick < 70 ? SEQ_FOUR : pick < 80 ? SEQ_NOISE : pick < 90 ? SEQ_TRUNCATED :
             SEQ_BAD_SECOND;
      case (kind)
        SEQ_NOISE: begin
          repeat ($urandom_range(1, 3)) begin
            seq.insert(seq.size(), byte_t'($urandom_range(0, 255)));
          end
        end
        SEQ_BAD_SECOND: begin
          case ($urandom_range(0, 3))
            0: begin
              seq.insert(seq.size(), u8cp_pkg::LEAD_E0);
              seq.insert(seq.size(), byte_t'($urandom_range(8'h80, 8'h9F)));
            end
            1: begin
              seq.insert(seq.size(), u8cp_pkg::LEAD_ED);
              seq.insert(seq.size(), byte_t'($urandom_range(8'hA0, 8'hBF)));
            end
            2: begin
              seq.insert(seq.size(), u8cp_pkg::LEAD_F0);
              seq.insert(seq.size(), byte_t'($urandom_range(8'h80, 8'h8F)));
            end
            default: begin
              seq.insert(seq.size(), u8cp_pkg::LEAD_F4);
              seq.insert(seq.size(), byte_t'($urandom_range(8'h90, 8'hBF)));
            end
          endcase
          seq.insert(seq.size(), u8cp_pkg::CONT_TAG | byte_t'($urandom_range(0, 63)));
        end
        default: begin
          case (kind)
            SEQ_ASCII: len = 1;
            SEQ_TWO:   len = 2;
            SEQ_THREE: len = 3;
            SEQ_FOUR:  len = 4;
            default:   len = $urandom_range(2, 4);
          endcase
          lo = len == 1 ? 21'h0 : len == 2 ? 21'h80 : len == 3 ? 21'h800 : 21'h10000;
          hi = len == 1 ? 21'h7F : len == 2 ? 21'h7FF : len == 3 ? 21'hFFFF :
               u8cp_pkg::MAX_SCALAR;
          // Hit the ends of each length's range now and then.
          if ($urandom_range(0, 7) == 0) begin
            cp = $urandom_range(0, 1) ? lo : hi;
          end else begin
            cp = cp_t'($urandom_range(lo, hi));
          end
          if (len == 3 && cp >= u8cp_pkg::SURR_LO && cp <= u8cp_pkg::SURR_HI) begin
            cp = cp ^ 21'h2000;
          end
          case (len)
            1: seq.insert(seq.size(), cp[7:0]);
            2: begin
              seq.insert(seq.size(), {3'b110, cp[10:6]});
              seq.insert(seq.size(), {2'b10, cp[5:0]});
            end
            3: begin
              seq.insert(seq.size(), {4'b1110, cp[15:12]});
              seq.insert(seq.size(), {2'b10, cp[11:6]});
              seq.insert(seq.size(), {2'b10, cp[5:0]});
            end
            default: begin
              seq.insert(seq.size(), {5'b11110, cp[20:18]});
              seq.insert(seq.size(), {2'b10, cp[17:12]});
              seq.insert(seq.size(), {2'b10, cp[11:6]});
              seq.insert(seq.size(), {2'b10, cp[5:0]});
            end
          endcase
          if (kind == SEQ_TRUNCATED) begin
            repeat ($urandom_range(1, len - 1)) void'(seq.pop_back());
          end
        end
      endcase
      last_of_text = ($urandom_range(0, 7) == 0);
      send_text(seq, last_of_text);
      sent += seq.size();
    end
  endtask

  // The receiver stops for a long stretch while bytes keep coming.
  task automatic test_output_backpressure();
    hold_request = HOLD_CYCLES;
    send_random_text(24);
  endtask

  // The sender stops until every code point has come out, then goes on.
  task automatic test_drain_pause();
    send_random_text(10);
    byte_ch.valid <= 1'b0;
    wait_drained();
    send_random_text(10);
  endtask

  // Receiver side: random stalls, or a counted hold-off on request.
  initial begin
    point_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        point_ch.ready <= 1'b0;
      end else begin
        point_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Compare each code point beat with the oldest expectation.
  always @(posedge clk) begin : check_points
    point_t want;
    if (!rst && point_ch.valid && point_ch.ready) begin
      if (pending_points.size() == 0) begin
        note_failure($sformatf("unexpected code point %h run_last %b text_last %b",
                               point_ch.code_point, point_ch.run_last, point_ch.text_last));
      end else begin
        want = pending_points.pop_front();
        if (want.code_point !== point_ch.code_point || want.run_last !== point_ch.run_last ||
            want.text_last !== point_ch.text_last) begin
          note_failure($sformatf("expected %h/%b/%b, got %h/%b/%b",
                                 want.code_point, want.run_last, want.text_last,
                                 point_ch.code_point, point_ch.run_last,
                                 point_ch.text_last));
        end
      end
    end
  end

  // Stop the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (point_ch.valid && point_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("utf8_to_codepoint_decoder verification failed");
        $finish;
      end
    end
  end

  initial begin
    byte_ch.valid <= 1'b0;
    byte_ch.in_byte <= '0;
    byte_ch.stream_end <= 1'b0;
    seq_lead = '0;
    seq_cont_count = 0;
    seq_cont[0] = '0;
    seq_cont[1] = '0;
    seq_open = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Sender mostly busy, receiver often stalled.
    send_idle_pct = 6;
    recv_idle_pct = 65;
    test_ascii();
    test_two_byte();
    test_three_byte();
    test_four_byte();
    test_second_byte_range();
    test_invalid_leads();
    test_interrupted_sequence();
    send_random_text(50);

    // Sender often idle, receiver mostly ready.
    send_idle_pct = 65;
    recv_idle_pct = 6;
    send_random_text(40);

    // Neither side idles.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_text(10);
    test_output_backpressure();
    test_drain_pause();

    byte_ch.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("utf8_to_codepoint_decoder verification clean");
    end else begin
      $display("utf8_to_codepoint_decoder verification failed");
    end
    $finish;
  end

endmodule
